// ===== src/sliding_mode_controller_unit_defines.svh =====
// Assertion macros for the sliding mode controller unit.
`ifndef SLIDING_MODE_CONTROLLER_UNIT_DEFINES_SVH
`define SLIDING_MODE_CONTROLLER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SMC_ASSERT_HOLD(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("lbl failed");
`define SMC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lbl failed");
`else
`define SMC_ASSERT_HOLD(lbl, clk, rst_n, cond)
`define SMC_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== src/smc_pkg.sv =====
// ----------------------------------------------------------------------------
// smc_pkg
// Types, status codes and saturation helpers of the sliding mode controller.
// ----------------------------------------------------------------------------
`default_nettype none
package smc_pkg;
  localparam int FRAC_BITS = 16;
  localparam logic [31:0] US_PER_S = 32'd1000000;
  localparam logic signed [31:0] ONE_Q = 32'sd65536;

  localparam logic [2:0] ST_NORMAL = 3'd0;
  localparam logic [2:0] ST_BAD_STEP = 3'd1;
  localparam logic [2:0] ST_DEADBAND = 3'd2;
  localparam logic [2:0] ST_ZERO_GAIN = 3'd3;
  localparam logic [2:0] ST_CLAMPED = 3'd4;

  localparam logic [2:0] REG_DEADBAND = 3'd0;
  localparam logic [2:0] REG_SLOPE = 3'd1;
  localparam logic [2:0] REG_SWITCH = 3'd2;
  localparam logic [2:0] REG_LINEAR = 3'd3;
  localparam logic [2:0] REG_PLANT = 3'd4;
  localparam logic [2:0] REG_BOUNDARY = 3'd5;
  localparam logic [2:0] REG_LIMIT = 3'd6;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] setpoint;
    logic [19:0] step_time_us;
  } in_data_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic [2:0] status;
  } out_data_t;

  // Saturate a wide signed value into the 32-bit word range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Product scaled down by 2^FRAC_BITS with truncation toward zero.
  function automatic logic signed [31:0] qscale(input logic signed [64:0] p);
    logic signed [65:0] t;
    t = 66'(p);
    if (p[64]) t = t + 66'sd65535;
    return sat32(t >>> FRAC_BITS);
  endfunction
endpackage
`default_nettype wire

// ===== src/sliding_mode_controller_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_mode_controller_unit
// Sliding mode controller with exponential reaching law, Q16.16 saturating.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_data) takes one word holding
// position, velocity, setpoint and step time. The result channel (out_valid,
// out_stall, out_data) returns one word of drive and status per input word.
// Configuration is written through cfg_we, cfg_index and cfg_wdata, one
// register per cycle; the user must write it while the block is idle, which
// the block itself does not enforce. The result word appears in the cycle
// after acceptance for a zero step time. An error inside the deadband takes
// two serial divisions and any other word two to four, each of 54 steps,
// through one shared restoring divider, plus steps through one shared
// multiplier.
// in_stall stays high from acceptance until the result word is taken.
// A stalled result holds its value until out_stall drops.
// Reset clears the stored target and target rate and loads the register
// defaults; the block is ready in the first cycle after reset.
`default_nettype none
`include "sliding_mode_controller_unit_defines.svh"
module sliding_mode_controller_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire smc_pkg::in_data_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output smc_pkg::out_data_t out_data,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import smc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_E, S_DR, S_DDR_M, S_DDR, S_DB, S_S, S_BS, S_M2, S_M3, S_M4,
    S_IN, S_DIV, S_DONE, S_OUT
  } state_t;

  typedef enum logic [1:0] {R_DR, R_DDR, R_BS, R_DRV} ret_t;

  state_t state_r;
  ret_t ret_r;

  logic [30:0] deadband_r, boundary_r, limit_r;
  logic signed [31:0] slope_r, switch_r, linear_r, plant_r;
  logic signed [31:0] last_r, rate_r;
  logic signed [31:0] x_r, dx_r, sp_r;
  logic [19:0] us_r;
  logic signed [31:0] e_r, dr_r, ddr_r, s_r, bs_r, usw_r;
  logic signed [64:0] p_r;
  logic signed [31:0] drive_r;
  logic [2:0] status_r;

  logic [53:0] quo_r;
  logic [31:0] rem_r, dvs_r;
  logic [5:0] cnt_r;
  logic neg_r;

  // Shared multiplier operands.
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_E: begin
        mul_a = 33'(sp_r) - 33'(last_r);
        mul_b = $signed(US_PER_S);
      end
      S_DDR_M: begin
        mul_a = 33'(dr_r) - 33'(rate_r);
        mul_b = $signed(US_PER_S);
      end
      S_DB: begin
        mul_a = 33'(slope_r);
        mul_b = e_r;
      end
      S_M2: begin
        mul_a = 33'(switch_r);
        mul_b = bs_r;
      end
      S_M3: begin
        mul_a = 33'(linear_r);
        mul_b = s_r;
      end
      S_M4: begin
        mul_a = 33'(slope_r);
        mul_b = sat32(66'(dx_r) - 66'(dr_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 65'(mul_a) * 65'(mul_b);
  end

  // Divider step and signed quotient.
  logic [32:0] rem_sh;
  logic div_ge;
  logic signed [54:0] quo_s;
  logic signed [31:0] div_res;
  assign rem_sh = {rem_r, quo_r[53]};
  assign div_ge = rem_sh >= {1'b0, dvs_r};
  assign quo_s = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign div_res = sat32(66'(quo_s));

  logic [64:0] p_mag;
  assign p_mag = p_r[64] ? 65'(-p_r) : 65'(p_r);

  logic [32:0] e_mag, s_mag, inner_mag, g_mag;
  logic signed [31:0] inner;
  assign e_mag = e_r[31] ? 33'(-33'(e_r)) : 33'(e_r);
  assign s_mag = s_r[31] ? 33'(-33'(s_r)) : 33'(s_r);
  assign inner = sat32(66'(sat32(66'(usw_r) + 66'(qscale(p_r)))) - 66'(ddr_r));
  assign inner_mag = inner[31] ? 33'(-33'(inner)) : 33'(inner);
  assign g_mag = plant_r[31] ? 33'(-33'(plant_r)) : 33'(plant_r);

  logic signed [32:0] lim_s;
  assign lim_s = 33'({2'b00, limit_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      deadband_r <= '0;
      slope_r <= ONE_Q;
      switch_r <= ONE_Q;
      linear_r <= '0;
      plant_r <= ONE_Q;
      boundary_r <= 31'(ONE_Q);
      limit_r <= 31'd655360;
      last_r <= '0;
      rate_r <= '0;
      ret_r <= R_DR;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEADBAND: deadband_r <= cfg_wdata[30:0];
          REG_SLOPE: slope_r <= cfg_wdata;
          REG_SWITCH: switch_r <= cfg_wdata;
          REG_LINEAR: linear_r <= cfg_wdata;
          REG_PLANT: plant_r <= cfg_wdata;
          REG_BOUNDARY: boundary_r <= cfg_wdata[30:0];
          REG_LIMIT: limit_r <= cfg_wdata[30:0];
          default: ;
        endcase
      end
      p_r <= mul_p;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r <= in_data.position;
            dx_r <= in_data.velocity;
            sp_r <= in_data.setpoint;
            us_r <= in_data.step_time_us;
            if (in_data.step_time_us == '0) begin
              drive_r <= '0;
              status_r <= ST_BAD_STEP;
              state_r <= S_OUT;
            end else begin
              state_r <= S_E;
            end
          end
        end
        S_E: begin
          e_r <= sat32(66'(x_r) - 66'(sp_r));
          state_r <= S_DR;
        end
        S_DR, S_DDR: begin
          quo_r <= p_mag[53:0];
          rem_r <= '0;
          dvs_r <= 32'(us_r);
          neg_r <= p_r[64];
          cnt_r <= '0;
          ret_r <= (state_r == S_DR) ? R_DR : R_DDR;
          state_r <= S_DIV;
        end
        S_DDR_M: state_r <= S_DDR;
        S_DB: begin
          rate_r <= dr_r;
          last_r <= sp_r;
          if (e_mag < 33'(deadband_r)) begin
            drive_r <= '0;
            status_r <= ST_DEADBAND;
            state_r <= S_OUT;
          end else begin
            state_r <= S_S;
          end
        end
        S_S: begin
          s_r <= sat32(66'(sat32(66'(qscale(p_r)) + 66'(dx_r))) - 66'(dr_r));
          state_r <= S_BS;
        end
        S_BS: begin
          if (s_mag <= 33'(boundary_r)) begin
            if (boundary_r == '0) begin
              bs_r <= '0;
              state_r <= S_M2;
            end else begin
              quo_r <= 54'(s_mag) << FRAC_BITS;
              rem_r <= '0;
              dvs_r <= 32'(boundary_r);
              neg_r <= s_r[31];
              cnt_r <= '0;
              ret_r <= R_BS;
              state_r <= S_DIV;
            end
          end else begin
            bs_r <= s_r[31] ? -ONE_Q : ONE_Q;
            state_r <= S_M2;
          end
        end
        S_M2: state_r <= S_M3;
        S_M3: begin
          usw_r <= qscale(p_r);
          state_r <= S_M4;
        end
        S_M4: begin
          usw_r <= sat32(66'(usw_r) + 66'(qscale(p_r)));
          if (plant_r == '0) begin
            drive_r <= '0;
            status_r <= ST_ZERO_GAIN;
            state_r <= S_OUT;
          end else begin
            state_r <= S_IN;
          end
        end
        S_IN: begin
          // The drive is -inner / g, so it is negative when the signs agree.
          quo_r <= 54'(inner_mag) << FRAC_BITS;
          rem_r <= '0;
          dvs_r <= g_mag[31:0];
          neg_r <= (inner[31] == plant_r[31]);
          cnt_r <= '0;
          ret_r <= R_DRV;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= div_ge ? 32'(rem_sh - {1'b0, dvs_r}) : rem_sh[31:0];
          quo_r <= {quo_r[52:0], div_ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd53) state_r <= S_DONE;
        end
        S_DONE: begin
          unique case (ret_r)
            R_DR: begin
              dr_r <= div_res;
              state_r <= S_DDR_M;
            end
            R_DDR: begin
              ddr_r <= div_res;
              state_r <= S_DB;
            end
            R_BS: begin
              bs_r <= div_res;
              state_r <= S_M2;
            end
            R_DRV: begin
              if (33'(div_res) > lim_s) begin
                drive_r <= 32'(lim_s);
                status_r <= ST_CLAMPED;
              end else if (33'(div_res) < -lim_s) begin
                drive_r <= 32'(-lim_s);
                status_r <= ST_CLAMPED;
              end else begin
                drive_r <= div_res;
                status_r <= ST_NORMAL;
              end
              state_r <= S_OUT;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data.drive = drive_r;
  assign out_data.status = status_r;

  logic zero_path;
  assign zero_path = out_valid && (out_data.status == ST_BAD_STEP ||
                     out_data.status == ST_DEADBAND || out_data.status == ST_ZERO_GAIN);

  `SMC_ASSERT_HOLD(a_status_range, clk, rst_n, !out_valid || out_data.status <= ST_CLAMPED)
  `SMC_ASSERT_HOLD(a_zero_paths, clk, rst_n, !zero_path || out_data.drive == '0)
  `SMC_ASSERT_NEXT(a_accept_gap, clk, rst_n, in_valid && !in_stall, in_stall)
  `SMC_ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sliding mode controller unit: a local predictor
// computes drive and status for every accepted word, and a checker compares
// each result word in order. Directed corners, register sweeps and random
// trajectories run with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import smc_pkg::*;

  localparam longint CYCLE_LIMIT = 64'd3000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_data_t in_data;
  logic out_valid;
  logic out_stall;
  out_data_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;

  sliding_mode_controller_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the register file and the controller state.
  longint deadband_q, slope_q, switch_q, linear_q, plant_q, boundary_q, limit_q;
  longint prev_target, prev_target_rate;

  out_data_t expected_words[$];
  int error_count;
  longint cycle_count;
  bit hold_off;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint clip(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Fixed point product; SystemVerilog division truncates toward zero.
  function automatic longint fx_mul(longint a, longint b);
    return clip((a * b) / 65536);
  endfunction

  function automatic longint boundary_ratio(longint s);
    longint mag;
    mag = s < 0 ? -s : s;
    if (mag <= boundary_q) begin
      if (boundary_q == 0) return 0;
      return clip((s * 65536) / boundary_q);
    end
    return s > 0 ? 64'sd65536 : -64'sd65536;
  endfunction

  function automatic out_data_t predict_drive(in_data_t w);
    out_data_t o;
    longint x, dx, r, us, e, emag, dr, ddr, s, usw, inner, u;
    x = longint'(w.position);
    dx = longint'(w.velocity);
    r = longint'(w.setpoint);
    us = longint'({1'b0, w.step_time_us});
    u = 0;
    o.status = ST_NORMAL;
    if (us == 0) begin
      o.status = ST_BAD_STEP;
    end else begin
      e = clip(x - r);
      dr = clip(((r - prev_target) * 1000000) / us);
      ddr = clip(((dr - prev_target_rate) * 1000000) / us);
      emag = e < 0 ? -e : e;
      prev_target_rate = dr;
      prev_target = r;
      if (emag < deadband_q) begin
        o.status = ST_DEADBAND;
      end else begin
        s = clip(clip(fx_mul(slope_q, e) + dx) - dr);
        usw = clip(fx_mul(switch_q, boundary_ratio(s)) + fx_mul(linear_q, s));
        if (plant_q == 0) begin
          o.status = ST_ZERO_GAIN;
        end else begin
          inner = clip(clip(usw + fx_mul(slope_q, clip(dx - dr))) - ddr);
          u = clip((-(inner * 65536)) / plant_q);
          if (u > limit_q) begin
            u = limit_q;
            o.status = ST_CLAMPED;
          end else if (u < -limit_q) begin
            u = -limit_q;
            o.status = ST_CLAMPED;
          end
        end
      end
    end
    o.drive = u[31:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", longint'(out_data.drive), 0);
      end else begin
        out_data_t want;
        want = expected_words.pop_front();
        if (out_data.drive !== want.drive)
          report_mismatch("drive", longint'(out_data.drive), longint'(want.drive));
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
    end
  end

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  // Receiver stall pattern; a long hold-off overrides it.
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end else begin
        n = gap_length();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Valid stays high after an accepted word until the next gap or drain.
  task automatic send_word(in_data_t w);
    int n;
    n = gap_length();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(predict_drive(w));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEADBAND: deadband_q = longint'({1'b0, v[30:0]});
      REG_SLOPE: slope_q = longint'(signed'(v));
      REG_SWITCH: switch_q = longint'(signed'(v));
      REG_LINEAR: linear_q = longint'(signed'(v));
      REG_PLANT: plant_q = longint'(signed'(v));
      REG_BOUNDARY: boundary_q = longint'({1'b0, v[30:0]});
      REG_LIMIT: limit_q = longint'({1'b0, v[30:0]});
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [19:0] rand_step();
    case ($urandom_range(0, 9))
      0: return 20'd0;
      1: return 20'hfffff;
      2: return $urandom_range(1, 10);
      default: return $urandom_range(1, 1000000);
    endcase
  endfunction

  function automatic in_data_t tracking_word(longint x, longint r);
    in_data_t w;
    w.position = x[31:0];
    w.velocity = $urandom_range(0, 32'h7ffff) - 32'h40000;
    w.setpoint = r[31:0];
    w.step_time_us = $urandom_range(500, 20000);
    return w;
  endfunction

  task automatic test_directed();
    in_data_t w;
    logic [31:0] corner[5] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff};
    for (int i = 0; i < 5; i++) begin
      w.position = corner[i];
      w.velocity = corner[4 - i];
      w.setpoint = corner[(i + 2) % 5];
      w.step_time_us = (i == 2) ? 20'd0 : (i == 3 ? 20'hfffff : 20'd1);
      send_word(w);
    end
    // Step time above one second, then zero step time leaving state alone.
    w = '{32'h00010000, 32'h0, 32'h00020000, 20'd1048575};
    send_word(w);
    w.step_time_us = 20'd0;
    send_word(w);
    w.step_time_us = 20'd1000;
    send_word(w);
    // Deadband window edge: error exactly at and below the deadband.
    drain();
    write_reg(REG_DEADBAND, 32'h00008000);
    w = '{32'h00008000, 32'h100, 32'h0, 20'd1000};
    send_word(w);
    w.position = 32'h00007fff;
    send_word(w);
    w.position = 32'hffff8001;
    send_word(w);
    drain();
    write_reg(REG_DEADBAND, 32'h0);
    write_reg(REG_PLANT, 32'h0);
    w = '{32'h00050000, 32'h0, 32'h0, 20'd1000};
    send_word(w);
    drain();
    write_reg(REG_PLANT, 32'h00010000);
    write_reg(REG_BOUNDARY, 32'h0);
    send_word(w);
    w = '{32'h0, 32'h0, 32'h0, 20'd1000};
    send_word(w);
    drain();
    write_reg(REG_BOUNDARY, 32'h00010000);
    // Drive far past the limit on both sides, then exactly at the limit.
    write_reg(REG_LIMIT, 32'h00010000);
    write_reg(REG_SLOPE, 32'h0);
    w = '{32'h00050000, 32'h0, 32'h00050000, 20'd1000};
    send_word(w);
    send_word(w);
    w.velocity = 32'h00030000;
    send_word(w);
    drain();
  endtask

  task automatic test_config(int idx);
    write_reg(REG_DEADBAND, idx[0] ? 32'h0 : $urandom_range(0, 32'h40000));
    write_reg(REG_SLOPE, idx == 1 ? 32'h7fffffff : (idx == 2 ? 32'h80000000 : rand_word()));
    write_reg(REG_SWITCH, idx == 3 ? 32'h80000000 : rand_word());
    write_reg(REG_LINEAR, idx == 4 ? 32'h7fffffff : rand_word());
    write_reg(REG_PLANT, idx == 5 ? 32'h0 : (idx == 6 ? 32'h1 : rand_word()));
    write_reg(REG_BOUNDARY, idx == 7 ? 32'h7fffffff : (idx == 8 ? 32'h1 : $urandom));
    write_reg(REG_LIMIT, idx == 9 ? 32'h7fffffff : (idx == 10 ? 32'h0 : $urandom));
  endtask

  task automatic test_random(int count);
    in_data_t w;
    longint x, r;
    x = 0;
    r = 0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        w.position = rand_word();
        w.velocity = rand_word();
        w.setpoint = rand_word();
        w.step_time_us = rand_step();
      end else begin
        // Smooth tracking: target drifts, position follows it.
        r = clip(r + $urandom_range(0, 32'h3ffff) - 32'h20000);
        x = clip(r + $urandom_range(0, 32'h7ffff) - 32'h40000);
        w = tracking_word(x, r);
      end
      send_word(w);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(6);
      begin
        repeat (900) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_DEADBAND;
    cfg_wdata = '0;
    hold_off = 1'b0;
    error_count = 0;
    cycle_count = 0;
    deadband_q = 0;
    slope_q = 65536;
    switch_q = 65536;
    linear_q = 0;
    plant_q = 65536;
    boundary_q = 65536;
    limit_q = 655360;
    prev_target = 0;
    prev_target_rate = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    for (int phase = 0; phase < 12; phase++) begin
      test_config(phase);
      test_random(155);
      drain();
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
